// File: design/ssd_pkg.sv
// Shared types and constants for the scale settle detector.
// No dependencies.
package ssd_pkg;

    localparam int W_WT  = 18;
    localparam int W_OS  = 19;
    localparam int W_T   = 32;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] OC_NONE    = 3'd0;
    localparam logic [2:0] OC_LEARNED = 3'd1;
    localparam logic [2:0] OC_DISC    = 3'd2;
    localparam logic [2:0] OC_LOWFLOW = 3'd3;
    localparam logic [2:0] OC_UNREAS  = 3'd4;
    localparam logic [2:0] OC_CUPEND  = 3'd5;
    localparam logic [2:0] OC_DRIP    = 3'd6;
    localparam logic [2:0] OC_CUPRM   = 3'd7;

    localparam logic [2:0] REG_DRIFT = 3'd0;
    localparam logic [2:0] REG_HOLD  = 3'd1;
    localparam logic [2:0] REG_STILL = 3'd2;
    localparam logic [2:0] REG_MAXT  = 3'd3;
    localparam logic [2:0] REG_CUP   = 3'd4;
    localparam logic [2:0] REG_FLOW  = 3'd5;
    localparam logic [2:0] REG_DRIPM = 3'd6;
    localparam logic [2:0] REG_OVER  = 3'd7;

    localparam logic signed [W_WT-1:0] STILL_STEP = 18'sd10;
    localparam logic signed [W_WT-1:0] BELOW_MARGIN = 18'sd50;

    typedef struct packed {
        logic [9:0]  drift;
        logic [15:0] hold;
        logic [15:0] still;
        logic [15:0] maxt;
        logic [16:0] cup;
        logic [10:0] flow;
        logic [16:0] drip;
        logic [16:0] over;
    } cfg_t;

endpackage

// File: design/ssd_div.sv
// Restoring serial divider, one quotient bit per cycle: |num| / den, sign restored.
// Depends on ssd_pkg.
module ssd_div
    import ssd_pkg::*;
#(
    parameter int NW = 24,
    parameter int DW = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 busy,
    output logic signed [W_WT-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next = num[NW-1] ? NW'(-num) : NW'(num);
            r_next = '0; d_next = den; neg_next = num[NW-1];
            cnt_next = CW'(NW); busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? W_WT'(-q_reg) : W_WT'(q_reg);
endmodule

// File: design/scale_settle_detector_core.sv
// Scale settle detector top level: APB register file, window memory, sequencer.
// Depends on ssd_pkg and ssd_div.
// Each item takes a fixed pass through a sequencer: accept, window memory read, update,
// a divider start cycle, then a serial divide of the window sum by the fill count (one
// quotient bit per cycle), a step to leave the divide, evaluate, and the output register.
// The next item is accepted only once the result has been taken. The window store has
// no reset; entries are only used after they are written, so no clearing pass is needed.
module scale_settle_detector_core
    import ssd_pkg::*;
#(
    parameter int WINDOW_SIZE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: weight[17:0], weight_at_stop[35:18], flow_at_stop[46:36],
    //        target_weight[63:47], now_ms[95:64], scale_connected[96], pad to 104
    input  logic [103:0] s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: settling_active[0], outcome[3:1], final_weight[21:4], drip[39:22],
    //        overshoot[58:40], average[76:59], pad to 80
    output logic [79:0] m_tdata
);
    localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);
    localparam int SW = W_WT + IW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd6;

    // ---------------- configuration ----------------
    cfg_t cfg_reg;
    logic [2:0] ridx;
    assign ridx   = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drift <= 10'd10;   cfg_reg.hold <= 16'd1500;
            cfg_reg.still <= 16'd1000; cfg_reg.maxt <= 16'd10000;
            cfg_reg.cup   <= 17'd2000; cfg_reg.flow <= 11'd50;
            cfg_reg.drip  <= 17'd2000; cfg_reg.over <= 17'd2000;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_DRIFT: cfg_reg.drift <= pwdata[9:0];
                REG_HOLD:  cfg_reg.hold  <= pwdata[15:0];
                REG_STILL: cfg_reg.still <= pwdata[15:0];
                REG_MAXT:  cfg_reg.maxt  <= pwdata[15:0];
                REG_CUP:   cfg_reg.cup   <= pwdata[16:0];
                REG_FLOW:  cfg_reg.flow  <= pwdata[10:0];
                REG_DRIPM: cfg_reg.drip  <= pwdata[16:0];
                REG_OVER:  cfg_reg.over  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_DRIFT: prdata = {22'd0, cfg_reg.drift};
            REG_HOLD:  prdata = {16'd0, cfg_reg.hold};
            REG_STILL: prdata = {16'd0, cfg_reg.still};
            REG_MAXT:  prdata = {16'd0, cfg_reg.maxt};
            REG_CUP:   prdata = {15'd0, cfg_reg.cup};
            REG_FLOW:  prdata = {21'd0, cfg_reg.flow};
            REG_DRIPM: prdata = {15'd0, cfg_reg.drip};
            REG_OVER:  prdata = {15'd0, cfg_reg.over};
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- item fields ----------------
    logic [1:0]  op_reg;
    logic signed [W_WT-1:0] w_reg, wstop_in;
    logic [10:0] flow_in;
    logic [16:0] tgt_in;
    logic [W_T-1:0] now_reg;
    logic conn_reg;
    logic [63:18] td_reg;   // start-only fields

    assign wstop_in = td_reg[35:18];
    assign flow_in  = td_reg[46:36];
    assign tgt_in   = td_reg[63:47];

    // ---------------- state ----------------
    logic [2:0] st_reg;
    logic active_reg, stv_reg;
    logic [IW-1:0] widx_reg;
    logic [CW-1:0] wcnt_reg;
    logic signed [SW-1:0] wsum_reg;
    logic signed [W_WT-1:0] lavg_reg, cur_reg, peak_reg, sref_reg, sw_reg;
    logic [W_T-1:0] lct_reg, sts_reg, sst_reg;
    logic [10:0] sf_reg;
    logic [16:0] stg_reg;
    logic signed [W_WT-1:0] mem [WINDOW_SIZE];
    logic signed [W_WT-1:0] old_reg;
    logic [2:0] oc_reg;
    logic fin_reg;          // completion pending (tick, cup removal, still or held-average path)
    logic useavg_reg;       // completion takes the average as final weight
    logic stillhit_reg;     // sample saw stillness before update
    logic abort_reg;        // not a kept sample (start, tick, ignored or cup removed): no window eval
    logic [79:0] out_reg;
    logic ov_reg;

    // divider
    logic div_start, div_busy;
    logic signed [W_WT-1:0] div_q;
    ssd_div #(.NW(SW), .DW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(wsum_reg), .den(wcnt_reg), .busy(div_busy), .quo(div_q)
    );

    logic div_go_reg;
    logic signed [W_WT-1:0] avg_now;
    assign avg_now = (wcnt_reg == '0) ? lavg_reg : div_q;
    assign div_start = div_go_reg;

    // completion arithmetic on a chosen final weight
    logic signed [W_WT-1:0] fw;
    logic signed [W_WT+1:0] dr, os, osab, lim, peakl;
    logic [2:0] code;
    always_comb
    begin
        fw    = cur_reg;
        dr    = 20'(fw) - 20'(sw_reg);
        if (dr < 0)
            dr = '0;
        os    = 20'(fw) - $signed({3'd0, stg_reg});
        osab  = (os < 0) ? -os : os;
        lim   = $signed({3'd0, cfg_reg.cup});
        peakl = 20'(peak_reg) - lim;
        if (!conn_reg)
            code = OC_DISC;
        else if (sf_reg < cfg_reg.flow)
            code = OC_LOWFLOW;
        else if (fw < 0 || osab > $signed({3'd0, cfg_reg.over}))
            code = OC_UNREAS;
        else if (20'(peak_reg) > lim && 20'(fw) < peakl)
            code = OC_CUPEND;
        else if (dr > $signed({3'd0, cfg_reg.drip}))
            code = OC_DRIP;
        else
            code = OC_LEARNED;
    end

    // sample-side compares
    logic signed [W_WT+1:0] lim_s, curl, pkl, dref;
    logic signed [W_WT-1:0] pk_new;
    logic cup_rm;
    always_comb
    begin
        lim_s  = $signed({3'd0, cfg_reg.cup});
        pk_new = (w_reg > peak_reg) ? w_reg : peak_reg;
        curl   = 20'(cur_reg) - lim_s;
        pkl    = 20'(pk_new) - lim_s;
        cup_rm = (20'(cur_reg) > lim_s && 20'(w_reg) < curl) ||
                 (20'(pk_new) > lim_s && 20'(w_reg) < pkl);
        dref   = 20'(w_reg) - 20'(sref_reg);
    end

    // item kind and timer checks, all against state before the update
    logic is_smp, is_tick, still_hit, hold_hit, maxt_hit;
    always_comb
    begin
        is_smp    = (op_reg == OP_SAMPLE) && active_reg;
        is_tick   = (op_reg == OP_TICK) && active_reg;
        still_hit = (now_reg - lct_reg) >= {16'd0, cfg_reg.still};
        hold_hit  = stv_reg && ((now_reg - sts_reg) >= {16'd0, cfg_reg.hold});
        maxt_hit  = (now_reg - sst_reg) >= {16'd0, cfg_reg.maxt};
    end

    logic signed [W_WT+1:0] drift, below_lim;
    logic below, full;
    always_comb
    begin
        drift     = 20'(avg_now) - 20'(lavg_reg);
        if (drift < 0)
            drift = -drift;
        below_lim = 20'(sw_reg) - 20'(BELOW_MARGIN);
        below     = (sw_reg > 0) && (20'(avg_now) < below_lim);
        full      = (wcnt_reg == CW'(WINDOW_SIZE));
    end

    assign s_tready = (st_reg == S_IDLE) && !ov_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            td_reg  <= s_tdata[63:18];
            w_reg   <= s_tdata[17:0];
            now_reg <= s_tdata[95:64];
            conn_reg <= s_tdata[96];
            op_reg  <= s_tuser;
        end
        if (st_reg == S_RD)
            old_reg <= mem[widx_reg];
        if (st_reg == S_UPD && op_reg == OP_SAMPLE && active_reg && !cup_rm)
            mem[widx_reg] <= w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; active_reg <= 1'b0; stv_reg <= 1'b0;
            widx_reg <= '0; wcnt_reg <= '0; wsum_reg <= '0;
            lavg_reg <= '0; cur_reg <= '0; peak_reg <= '0; sref_reg <= '0;
            lct_reg <= '0; sts_reg <= '0; sst_reg <= '0;
            sw_reg <= '0; sf_reg <= '0; stg_reg <= '0;
            oc_reg <= OC_NONE; fin_reg <= 1'b0; useavg_reg <= 1'b0;
            stillhit_reg <= 1'b0; abort_reg <= 1'b0;
            out_reg <= '0; ov_reg <= 1'b0; div_go_reg <= 1'b0;
        end
        else
        begin
            // divider starts the cycle after the update
            div_go_reg <= (st_reg == S_UPD);
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                        st_reg <= S_RD;
                S_RD:
                    st_reg <= S_UPD;
                S_UPD:
                begin
                    oc_reg       <= (is_smp && cup_rm) ? OC_CUPRM : OC_NONE;
                    // tick order: stillness, held average, timeout
                    fin_reg      <= (is_smp && cup_rm) ||
                                    (is_tick && (still_hit || hold_hit || maxt_hit));
                    useavg_reg   <= is_tick && !still_hit && hold_hit;
                    stillhit_reg <= is_smp && !cup_rm && still_hit;
                    abort_reg    <= !(is_smp && !cup_rm);
                    if (op_reg == OP_START)
                    begin
                        cur_reg <= w_reg; sw_reg <= wstop_in; sf_reg <= flow_in;
                        stg_reg <= tgt_in; sref_reg <= w_reg; peak_reg <= w_reg;
                        lct_reg <= now_reg; sst_reg <= now_reg;
                        wcnt_reg <= '0; widx_reg <= '0; wsum_reg <= '0;
                        lavg_reg <= w_reg; stv_reg <= 1'b0; sts_reg <= '0;
                        active_reg <= 1'b1;
                    end
                    else if (is_smp)
                    begin
                        peak_reg <= pk_new;
                        if (cup_rm)
                            active_reg <= 1'b0;
                        else
                        begin
                            cur_reg <= w_reg;
                            wsum_reg <= wsum_reg + SW'(w_reg) -
                                        (full ? SW'(old_reg) : SW'(0));
                            widx_reg <= (widx_reg == IW'(WINDOW_SIZE - 1)) ? '0
                                        : widx_reg + 1'b1;
                            if (!full)
                                wcnt_reg <= wcnt_reg + 1'b1;
                            if (dref >= 20'(STILL_STEP) || dref <= -20'(STILL_STEP))
                            begin
                                sref_reg <= w_reg;
                                lct_reg <= now_reg;
                            end
                        end
                    end
                    st_reg <= S_DIV;
                end
                S_DIV:
                    if (!div_go_reg && !div_busy)
                        st_reg <= S_EVAL;
                S_EVAL:
                begin
                    st_reg <= S_OUT;
                    if (!abort_reg)
                    begin
                        lavg_reg <= avg_now;
                        if (stillhit_reg)
                            fin_reg <= 1'b1;
                        else if (full)
                        begin
                            if (drift < $signed({10'd0, cfg_reg.drift}) && !below)
                            begin
                                if (!stv_reg)
                                begin
                                    stv_reg <= 1'b1;
                                    sts_reg <= now_reg;
                                end
                                if ((now_reg - (stv_reg ? sts_reg : now_reg)) >=
                                    {16'd0, cfg_reg.hold})
                                begin
                                    fin_reg <= 1'b1;
                                    cur_reg <= avg_now;
                                end
                            end
                            else
                            begin
                                stv_reg <= 1'b0;
                                sts_reg <= '0;
                            end
                        end
                    end
                    else if (useavg_reg)
                        cur_reg <= avg_now;
                end
                S_OUT:
                    if (!ov_reg)
                    begin
                        if (fin_reg && oc_reg != OC_CUPRM)
                            active_reg <= 1'b0;
                        out_reg <= {3'd0, avg_now,
                                    fin_reg ? os[W_OS-1:0] : {W_OS{1'b0}},
                                    fin_reg ? dr[W_WT-1:0] : {W_WT{1'b0}},
                                    fin_reg ? fw : {W_WT{1'b0}},
                                    fin_reg ? ((oc_reg == OC_CUPRM) ? OC_CUPRM : code)
                                            : OC_NONE,
                                    active_reg && !fin_reg};
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_tready)
        else $error("accepting while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid || $past(m_tvalid))
        else $error("result without work");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= CW'(WINDOW_SIZE))
        else $error("window count overflow");
`endif
endmodule
